// ===== rtl/sync_length_xor_frame_receiver_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Frame receiver assertion macros
// Shared assertion shorthands for the frame receiver checkers.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication
`define SLXFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver check failed");

// next-cycle implication
`define SLXFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver check failed");

`endif

// ===== rtl/slxfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame receiver package
// Shared types, codes and constants of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package slxfr_pkg;

   localparam int RING_DEPTH_DEFAULT = 256;
   localparam logic [7:0] SYNC_RESET = 8'd164;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2,
      PH_CHK  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_IGNORED = 2'd0,
      ST_TAKEN   = 2'd1,
      ST_GOOD    = 2'd2,
      ST_BAD     = 2'd3
   } status_type;

   typedef struct packed {
      logic       store_valid;
      logic [7:0] store_address;
      logic [7:0] store_data;
      status_type status;
      logic [7:0] message_total;
      logic [7:0] next_write_address;
   } result_type;

   function automatic logic [7:0] low_byte(input logic [31:0] value);
      return value[7:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/slxfr_deframer.sv =====
// ----------------------------------------------------------------------------
// Frame receiver deframer
// Frame phase tracking, running XOR, write pointer and good-frame count.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfr_deframer
   import slxfr_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT,
   localparam int AW = $clog2(RING_DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [7:0]    rx_byte,
   input  wire logic          assume_sync,
   input  wire logic [7:0]    sync_byte,
   output logic               wr_enable,
   output logic [AW-1:0]      wr_address,
   output logic [7:0]         wr_data,
   output result_type         result
);

   phase_type     phase_ff,      phase_in;
   logic [8:0]    bytes_left_ff, bytes_left_in;
   logic [7:0]    xor_ff,        xor_in;
   logic [AW-1:0] wptr_ff,       wptr_in;
   logic [AW-1:0] start_ff,      start_in;
   logic [7:0]    count_ff,      count_in;

   logic          frame_start;
   logic          chk_ok;
   logic [AW-1:0] wptr_inc;
   status_type    status;

   assign frame_start = assume_sync || (rx_byte == sync_byte);
   assign chk_ok      = (rx_byte == xor_ff);
   assign wptr_inc    = (wptr_ff == AW'(RING_DEPTH - 1)) ? '0 : wptr_ff + AW'(1);

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (frame_start) begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            phase_in = PH_DATA;
         end
         PH_DATA: begin
            if (bytes_left_ff <= 9'd1) begin
               phase_in = PH_CHK;
            end
         end
         PH_CHK: begin
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      wr_enable     = 1'b0;
      wr_data       = rx_byte;
      status        = ST_IGNORED;
      bytes_left_in = bytes_left_ff;
      xor_in        = xor_ff;
      wptr_in       = wptr_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (frame_start) begin
               wr_enable = 1'b1;
               wr_data   = sync_byte;
               status    = ST_TAKEN;
               xor_in    = sync_byte;
               start_in  = wptr_ff;
               wptr_in   = wptr_inc;
            end
         end
         PH_LEN: begin
            wr_enable     = 1'b1;
            status        = ST_TAKEN;
            xor_in        = xor_ff ^ rx_byte;
            bytes_left_in = {1'b0, rx_byte} + 9'd1;
            wptr_in       = wptr_inc;
         end
         PH_DATA: begin
            wr_enable = 1'b1;
            status    = ST_TAKEN;
            xor_in    = xor_ff ^ rx_byte;
            wptr_in   = wptr_inc;
            if (bytes_left_ff != 9'd0) begin
               bytes_left_in = bytes_left_ff - 9'd1;
            end
         end
         PH_CHK: begin
            if (chk_ok) begin
               wr_enable = 1'b1;
               status    = ST_GOOD;
               wptr_in   = wptr_inc;
               count_in  = count_ff + 8'd1;
            end else begin
               status  = ST_BAD;
               wptr_in = start_ff;
            end
         end
         default: begin
            status = ST_IGNORED;
         end
      endcase
   end

   assign wr_address = wptr_ff;

   always_comb begin
      result.store_valid        = wr_enable;
      result.store_address      = wr_enable ? low_byte(32'(wptr_ff)) : 8'd0;
      result.store_data         = wr_enable ? wr_data : 8'd0;
      result.status             = status;
      result.message_total      = count_in;
      result.next_write_address = low_byte(32'(wptr_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bytes_left_ff <= '0;
         xor_ff        <= '0;
         wptr_ff       <= '0;
         start_ff      <= '0;
         count_ff      <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         xor_ff        <= xor_in;
         wptr_ff       <= wptr_in;
         start_ff      <= start_in;
         count_ff      <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sync_length_xor_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// Sync/length/XOR frame receiver.
// Input channel (req_): one received byte per transfer, with an assume-sync
// flag that opens a frame from idle in place of a matching sync byte.
// Result channel (rsp_): one result per input transfer, carrying the ring
// buffer write (valid, address, data), the frame status, the good-frame
// count and the write pointer after the byte.
// csr_: a single write-only register holding the sync byte value.
// Latency: a result is presented on the cycle after its input transfer.
// Throughput: one byte per cycle while req_stall is low; each byte costs
// at most one write on the single write port of the ring memory and one
// update of the frame state. Reset: frame state idle, pointers and counters
// zero, sync byte 0xA4. Ring contents are undefined until written.
// Stall: a held result keeps its register; req_stall rises while a result
// waits and rsp_stall is high, and falls in the cycle the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_xor_frame_receiver_unit
   import slxfr_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_assume_sync,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_store_valid,
   output logic [7:0]      rsp_store_address,
   output logic [7:0]      rsp_store_data,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_message_total,
   output logic [7:0]      rsp_next_write_address,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data
);

   localparam int AW = $clog2(RING_DEPTH);

   logic [7:0]    sync_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    result_ff;
   result_type    result;
   logic          step;
   logic          wr_enable;
   logic [AW-1:0] wr_address;
   logic [7:0]    wr_data;
   logic [7:0]    ring_mem [RING_DEPTH];

   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign step         = req_valid && !req_stall;
   assign rsp_valid_in = step || (rsp_valid_ff && rsp_stall);

   slxfr_deframer #(
      .RING_DEPTH (RING_DEPTH)
   ) u_deframer (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (req_rx_byte),
      .assume_sync (req_assume_sync),
      .sync_byte   (sync_ff),
      .wr_enable   (wr_enable),
      .wr_address  (wr_address),
      .wr_data     (wr_data),
      .result      (result)
   );

   // ring buffer
   always_ff @(posedge clock) begin
      if (step && wr_enable) begin
         ring_mem[wr_address] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
      end else if (csr_write_enable) begin
         sync_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result while stalled
   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_store_valid        = result_ff.store_valid;
   assign rsp_store_address      = result_ff.store_address;
   assign rsp_store_data         = result_ff.store_data;
   assign rsp_status             = result_ff.status;
   assign rsp_message_total      = result_ff.message_total;
   assign rsp_next_write_address = result_ff.next_write_address;

endmodule

`default_nettype wire

// ===== rtl/slxfr_checker.sv =====
// ----------------------------------------------------------------------------
// Frame receiver checker
// Port-level assertions on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_length_xor_frame_receiver_unit_defines.svh"

module slxfr_checker
   import slxfr_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_store_valid,
   input wire logic [7:0] rsp_store_address,
   input wire logic [7:0] rsp_store_data,
   input wire logic [1:0] rsp_status
);

   `SLXFR_ASSERT_NOW(a_no_store_zero, clock, reset, rsp_valid && !rsp_store_valid, rsp_store_address == 8'd0 && rsp_store_data == 8'd0)

   `SLXFR_ASSERT_NOW(a_status_store, clock, reset, rsp_valid, rsp_store_valid == (rsp_status == ST_TAKEN || rsp_status == ST_GOOD))

   `SLXFR_ASSERT_NOW(a_backpressure, clock, reset, rsp_valid && rsp_stall, req_stall)

   `SLXFR_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_store_data))

endmodule

bind sync_length_xor_frame_receiver_unit slxfr_checker u_slxfr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_store_valid   (rsp_store_valid),
   .rsp_store_address (rsp_store_address),
   .rsp_store_data    (rsp_store_data),
   .rsp_status        (rsp_status)
);

`default_nettype wire

// ===== dv/sync_length_xor_frame_receiver_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Feeds received bytes into the sync/length/XOR frame receiver, both as
// frames with random content, some with a bad checksum, and as noise, over
// several sync byte settings. A model of the framing state predicts every
// result, and each result transfer is compared field by field with it.
// ----------------------------------------------------------------------------

module sync_length_xor_frame_receiver_unit_tb;
   import slxfr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 250;
   localparam int PRINT_LIMIT = 20;

   typedef struct {
      logic [7:0] rx_byte;
      logic       assume_sync;
   } rx_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_assume_sync = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_store_valid;
   logic [7:0] rsp_store_address;
   logic [7:0] rsp_store_data;
   logic [1:0] rsp_status;
   logic [7:0] rsp_message_total;
   logic [7:0] rsp_next_write_address;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   rx_item_type pending_bytes[$];
   result_type  expected_results[$];
   rx_item_type next_item;

   // framing state as the block should hold it
   phase_type   rx_phase = PH_IDLE;
   logic [8:0]  rx_left = '0;
   logic [7:0]  rx_xor = '0;
   logic [7:0]  rx_wptr = '0;
   logic [7:0]  rx_frame_start = '0;
   logic [7:0]  rx_good_count = '0;
   logic [7:0]  rx_sync = SYNC_RESET;

   logic [7:0]  cfg_sync = SYNC_RESET;
   logic        req_done = 1'b0;
   bit          sender_pause = 1'b0;
   bit          no_idle = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_served = 1'b0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          items_queued = 0;
   int          items_accepted = 0;
   int          fail_count = 0;
   int          frames_good = 0;
   int          frames_bad = 0;
   int          sync_settings = 1;

   sync_length_xor_frame_receiver_unit DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_rx_byte            (req_rx_byte),
      .req_assume_sync        (req_assume_sync),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_store_valid        (rsp_store_valid),
      .rsp_store_address      (rsp_store_address),
      .rsp_store_data         (rsp_store_data),
      .rsp_status             (rsp_status),
      .rsp_message_total      (rsp_message_total),
      .rsp_next_write_address (rsp_next_write_address),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic void store_into_ring(input logic [7:0] b, inout result_type r);
      r.store_valid = 1'b1;
      r.store_address = rx_wptr;
      r.store_data = b;
      rx_wptr = rx_wptr + 8'd1;
   endfunction

   function automatic result_type predict_receive(input logic [7:0] rx, input logic flag);
      result_type r;
      r = '0;
      r.status = ST_IGNORED;
      case (rx_phase)
         PH_IDLE: begin
            if (flag || rx == rx_sync) begin
               rx_frame_start = rx_wptr;
               store_into_ring(rx_sync, r);
               rx_xor = rx_sync;
               rx_phase = PH_LEN;
               r.status = ST_TAKEN;
            end
         end
         PH_LEN: begin
            store_into_ring(rx, r);
            rx_xor = rx_xor ^ rx;
            rx_left = {1'b0, rx} + 9'd1;
            rx_phase = PH_DATA;
            r.status = ST_TAKEN;
         end
         PH_DATA: begin
            store_into_ring(rx, r);
            rx_xor = rx_xor ^ rx;
            if (rx_left != 9'd0)
               rx_left = rx_left - 9'd1;
            if (rx_left == 9'd0)
               rx_phase = PH_CHK;
            r.status = ST_TAKEN;
         end
         default: begin
            if (rx == rx_xor) begin
               store_into_ring(rx, r);
               rx_good_count = rx_good_count + 8'd1;
               r.status = ST_GOOD;
            end else begin
               rx_wptr = rx_frame_start;
               r.status = ST_BAD;
            end
            rx_phase = PH_IDLE;
         end
      endcase
      r.message_total = rx_good_count;
      r.next_write_address = rx_wptr;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      if (fail_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %02h want %02h", cycle_count, what, got, want);
      fail_count++;
   endtask

   // sender: advance only once the offered byte has been taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         if (pending_bytes.size() != 0 && !sender_pause &&
             (no_idle || $urandom_range(99) >= 7)) begin
            next_item = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_rx_byte <= next_item.rx_byte;
            req_assume_sync <= next_item.assume_sync;
         end else begin
            req_valid <= 1'b0;
            req_rx_byte <= 8'($urandom);
            req_assume_sync <= 1'($urandom);
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_request && !hold_served) begin
         hold_served <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 7);
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rx_phase = PH_IDLE;
         rx_left = '0;
         rx_xor = '0;
         rx_wptr = '0;
         rx_frame_start = '0;
         rx_good_count = '0;
         rx_sync = SYNC_RESET;
         req_done <= 1'b0;
      end else begin
         if (csr_write_enable)
            rx_sync = csr_write_data;
         req_done <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_receive(req_rx_byte, req_assume_sync));
            items_accepted <= items_accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected, status", 8'(rsp_status), 8'h00);
            end else begin
               want = expected_results.pop_front();
               if (want.status == ST_GOOD)
                  frames_good++;
               if (want.status == ST_BAD)
                  frames_bad++;
               if (rsp_store_valid !== want.store_valid)
                  report_mismatch("store_valid", 8'(rsp_store_valid), 8'(want.store_valid));
               if (rsp_store_address !== want.store_address)
                  report_mismatch("store_address", rsp_store_address, want.store_address);
               if (rsp_store_data !== want.store_data)
                  report_mismatch("store_data", rsp_store_data, want.store_data);
               if (rsp_status !== want.status)
                  report_mismatch("status", 8'(rsp_status), 8'(want.status));
               if (rsp_message_total !== want.message_total)
                  report_mismatch("message_total", rsp_message_total, want.message_total);
               if (rsp_next_write_address !== want.next_write_address)
                  report_mismatch("next_write_address", rsp_next_write_address,
                                  want.next_write_address);
            end
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic flag);
      rx_item_type it;
      it.rx_byte = b;
      it.assume_sync = flag;
      pending_bytes.push_back(it);
      items_queued++;
   endtask

   // sync, length, id, payload, checksum; flag_pct sets the flag on the bytes after sync
   task automatic add_frame(input int unsigned len, input bit good, input bit by_flag,
                            input int flag_pct);
      logic [7:0]  sum;
      logic [7:0]  b;
      int unsigned k;
      sum = cfg_sync;
      queue_byte(by_flag ? 8'($urandom) : cfg_sync, by_flag);
      for (k = 0; k < len + 2; k++) begin
         b = (k == 0) ? 8'(len) : 8'($urandom);
         sum = sum ^ b;
         queue_byte(b, $urandom_range(99) < flag_pct);
      end
      if (!good)
         sum = sum ^ 8'($urandom_range(1, 255));
      queue_byte(sum, $urandom_range(99) < flag_pct);
   endtask

   task automatic add_random(input int n);
      int         start;
      int unsigned len;
      logic [7:0] b;
      start = items_queued;
      while (items_queued - start < n) begin
         if ($urandom_range(99) < 80) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(8);
            add_frame(len, $urandom_range(99) < 85, $urandom_range(99) < 30,
                      ($urandom_range(99) < 20) ? 25 : 0);
         end else begin
            repeat ($urandom_range(1, 3)) begin
               b = 8'($urandom);
               if ($urandom_range(9) == 0) begin
                  queue_byte(b, 1'($urandom));
               end else begin
                  if (b == cfg_sync)
                     b = b ^ 8'h01;
                  queue_byte(b, 1'b0);
               end
            end
         end
      end
   endtask

   task automatic drain_all();
      @(negedge clock);
      while (items_accepted != items_queued || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_sync(input logic [7:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      cfg_sync = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sync_settings++;
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle bytes, short frames, flag starts, flag inside a frame
      @(posedge clock);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      add_frame(0, 1'b1, 1'b0, 0);
      add_frame(1, 1'b0, 1'b1, 0);
      add_frame(2, 1'b1, 1'b0, 100);
      add_frame(0, 1'b0, 1'b1, 0);
      add_frame(3, 1'b1, 1'b1, 50);
      drain_all();

      // quiet stretch: no idling on either side
      write_sync(8'h00);
      @(posedge clock);
      no_idle = 1'b1;
      add_random(120);
      drain_all();
      @(posedge clock);
      no_idle = 1'b0;

      // longest lengths, with a long receiver hold-off
      write_sync(8'hFF);
      @(posedge clock);
      add_random(40);
      add_frame(254, 1'b1, 1'b0, 0);
      add_frame(255, 1'b1, 1'b1, 10);
      add_frame(255, 1'b0, 1'b0, 0);
      add_random(40);
      while (pending_bytes.size() > 400)
         @(posedge clock);
      hold_request = 1'b1;
      drain_all();

      // random sync value, with a sender pause midway
      write_sync(8'($urandom));
      @(posedge clock);
      add_random(160);
      while (pending_bytes.size() > 80)
         @(posedge clock);
      sender_pause = 1'b1;
      @(negedge clock);
      while (req_valid || expected_results.size() != 0)
         @(negedge clock);
      @(posedge clock);
      sender_pause = 1'b0;
      drain_all();

      if (expected_results.size() != 0)
         report_mismatch("results left over, count", 8'(expected_results.size()), 8'h00);
      $display("Run covered %0d byte transfers under %0d sync settings,", items_accepted,
               sync_settings);
      $display("with %0d good frames and %0d checksum failures.", frames_good, frames_bad);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/slxfr_pkg.sv
rtl/slxfr_deframer.sv
rtl/sync_length_xor_frame_receiver_unit.sv
rtl/slxfr_checker.sv
dv/sync_length_xor_frame_receiver_unit_tb.sv
